// ===== rtl/snsu_pkg.sv =====
// Package for the search node statistics update block.
// Holds sizes, operation and fault codes, payload and table entry types,
// and the saturation helpers. No dependencies.
package snsu_pkg;

    // Table and number format sizes.
    localparam int NODES     = 1024;
    localparam int ADDR_W    = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int FRAC_BITS = 14;
    localparam int NODE_W    = 10;
    localparam int WL_W      = 16;
    localparam int M_W       = 24;
    localparam int VIS_W     = 32;
    localparam int PEND_W    = 16;
    localparam int MV_W      = 12;
    localparam int DIFF_W    = M_W + 1;
    localparam int MAG_W     = DIFF_W - 1;
    localparam int NUM_W     = MAG_W + MV_W;
    localparam int DEN_W     = VIS_W + 1;
    localparam int Q_W       = NUM_W + 1;
    localparam int SUM_W     = NUM_W + 2;
    localparam int LANES     = 3;
    localparam int LANE_WL   = 0;
    localparam int LANE_D    = 1;
    localparam int LANE_M    = 2;

    // Fixed point plus and minus one, saturated to the 16-bit field.
    localparam logic signed [WL_W-1:0] Q_ONE =
        (FRAC_BITS >= WL_W - 1) ? 16'sh7FFF : WL_W'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [WL_W-1:0] Q_NEG_ONE =
        (FRAC_BITS >= WL_W - 1) ? 16'sh8000 : WL_W'(-(64'sd1 <<< FRAC_BITS));

    // Operation codes; the spare code behaves as a read.
    localparam logic [2:0] OP_START  = 3'd0;
    localparam logic [2:0] OP_CANCEL = 3'd1;
    localparam logic [2:0] OP_FINAL  = 3'd2;
    localparam logic [2:0] OP_ADJUST = 3'd3;
    localparam logic [2:0] OP_REVERT = 3'd4;
    localparam logic [2:0] OP_MAKE   = 3'd5;
    localparam logic [2:0] OP_READ   = 3'd6;

    // Fault codes.
    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_DIV0  = 2'd1;
    localparam logic [1:0] FAULT_RANGE = 2'd2;

    // Game results for make terminal.
    localparam logic [1:0] RES_DRAW  = 2'd0;
    localparam logic [1:0] RES_WHITE = 2'd1;
    localparam logic [1:0] RES_BLACK = 2'd2;

    typedef struct packed {
        logic [2:0]               operation;
        logic [NODE_W-1:0]        node;
        logic signed [WL_W-1:0]   value_wl;
        logic signed [WL_W-1:0]   value_d;
        logic signed [M_W-1:0]    value_m;
        logic [MV_W-1:0]          multivisit;
        logic [1:0]               game_result;
        logic [1:0]               terminal_kind;
    } req_t;

    typedef struct packed {
        logic                     accepted;
        logic [1:0]               fault;
        logic signed [WL_W-1:0]   mean_wl;
        logic signed [WL_W-1:0]   mean_d;
        logic signed [M_W-1:0]    mean_m;
        logic [VIS_W-1:0]         visits;
        logic [PEND_W-1:0]        pending;
    } rsp_t;

    // One row of the statistics table.
    typedef struct packed {
        logic signed [WL_W-1:0]   wl;
        logic signed [WL_W-1:0]   d;
        logic signed [M_W-1:0]    m;
        logic [VIS_W-1:0]         visits;
        logic [PEND_W-1:0]        pending;
        logic [1:0]               kind;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_PREP,
        ST_MUL,
        ST_DGO,
        ST_DWAIT,
        ST_UPD
    } state_t;

    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

    // Saturate a wide sum to the 16-bit mean field.
    function automatic logic signed [WL_W-1:0] sat_wl(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'((64'sd1 <<< (WL_W - 1)) - 64'sd1);
        lo = -hi - SUM_W'(1);
        if (v > hi)
            return hi[WL_W-1:0];
        else if (v < lo)
            return lo[WL_W-1:0];
        else
            return v[WL_W-1:0];
    endfunction

    // Saturate a wide sum to the 24-bit plies-left field.
    function automatic logic signed [M_W-1:0] sat_m(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'((64'sd1 <<< (M_W - 1)) - 64'sd1);
        lo = -hi - SUM_W'(1);
        if (v > hi)
            return hi[M_W-1:0];
        else if (v < lo)
            return lo[M_W-1:0];
        else
            return v[M_W-1:0];
    endfunction

endpackage

// ===== rtl/snsu_if.sv =====
// Handshake channels of the search node statistics update block.
// Depends on snsu_pkg for the payload types.
interface snsu_req_if;
    logic               valid;
    logic               ready;
    snsu_pkg::req_t     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface snsu_rsp_if;
    logic               valid;
    logic               ready;
    snsu_pkg::rsp_t     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/snsu_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module snsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/snsu_divider.sv =====
// Three-lane restoring divider sharing one divisor, one quotient bit per cycle.
// Depends on snsu_pkg for sizes and the control and status structs.
module snsu_divider (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  snsu_pkg::div_ctl_t                          ctl,
    output snsu_pkg::div_sts_t                          sts,
    input  logic [snsu_pkg::LANES-1:0][snsu_pkg::NUM_W-1:0] num,
    input  logic [snsu_pkg::DEN_W-1:0]                  den,
    output logic [snsu_pkg::LANES-1:0][snsu_pkg::NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(snsu_pkg::NUM_W);

    logic [snsu_pkg::LANES-1:0][snsu_pkg::NUM_W-1:0] quo_reg;
    logic [snsu_pkg::LANES-1:0][snsu_pkg::NUM_W-1:0] quo_next;
    logic [snsu_pkg::LANES-1:0][snsu_pkg::DEN_W-1:0] rem_reg;
    logic [snsu_pkg::LANES-1:0][snsu_pkg::DEN_W-1:0] rem_next;
    logic [snsu_pkg::DEN_W-1:0]                      den_reg;
    logic [CNT_W-1:0]                                cnt_reg;
    logic                                            busy_reg;
    logic                                            done_reg;

    // One restoring step per lane: shift in the next numerator bit, trial subtract.
    always_comb
    begin
        for (int l = 0; l < snsu_pkg::LANES; l++)
        begin
            logic [snsu_pkg::DEN_W:0]   shifted;
            logic [snsu_pkg::DEN_W+1:0] trial;
            shifted = {rem_reg[l], quo_reg[l][snsu_pkg::NUM_W-1]};
            trial   = {1'b0, shifted} - {2'b00, den_reg};
            if (trial[snsu_pkg::DEN_W+1])
            begin
                rem_next[l] = shifted[snsu_pkg::DEN_W-1:0];
                quo_next[l] = {quo_reg[l][snsu_pkg::NUM_W-2:0], 1'b0};
            end
            else
            begin
                rem_next[l] = trial[snsu_pkg::DEN_W-1:0];
                quo_next[l] = {quo_reg[l][snsu_pkg::NUM_W-2:0], 1'b1};
            end
        end
    end

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(snsu_pkg::NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and partial remainder registers.
    always_ff @(posedge clk)
    begin
        if (ctl.start && !busy_reg)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quo      = quo_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

// ===== rtl/search_node_statistics_update.sv =====
// Top level of the search node statistics update block.
// Depends on snsu_pkg, snsu_if, snsu_ram and snsu_divider.

// Keeps per-node search statistics in one 1024-row table and applies one operation per
// transaction, returning the row after the operation. After reset the block clears every
// row of the table and accepts no request until that pass ends. Each request is handled on
// its own: start, cancel, make terminal and read go from the row lookup through operand
// preparation to the update, while finalize, adjust terminal and revert terminal with a
// nonzero divisor also pass through the multiply step and the shared three-lane divider,
// which produces one quotient bit per cycle over 36 bits. A finished result waits in an
// output register, and the next request is taken as soon as the row has been written back.
module search_node_statistics_update (
    input  logic              clk,
    input  logic              rst_n,
    snsu_req_if.sink          req,
    snsu_rsp_if.source        rsp
);

    snsu_pkg::state_t  state_reg;
    snsu_pkg::state_t  state_next;

    logic [snsu_pkg::ADDR_W-1:0] clr_cnt_reg;
    snsu_pkg::req_t    req_reg;
    snsu_pkg::entry_t  ent_reg;
    snsu_pkg::rsp_t    rsp_reg;
    snsu_pkg::rsp_t    rsp_next;
    logic              rsp_valid_reg;

    logic signed [snsu_pkg::DIFF_W-1:0] diff_reg [snsu_pkg::LANES];
    logic signed [snsu_pkg::DIFF_W-1:0] diff_next [snsu_pkg::LANES];
    logic [snsu_pkg::DEN_W-1:0]         den_reg;
    logic [snsu_pkg::DEN_W-1:0]         den_next;
    logic                               need_div;
    logic [snsu_pkg::LANES-1:0][snsu_pkg::NUM_W-1:0] prod_reg;
    logic [snsu_pkg::LANES-1:0]         neg_reg;
    logic [snsu_pkg::LANES-1:0][snsu_pkg::NUM_W-1:0] quo;

    snsu_pkg::div_ctl_t div_ctl;
    snsu_pkg::div_sts_t div_sts;

    logic                         ram_we;
    logic [snsu_pkg::ADDR_W-1:0]  ram_waddr;
    snsu_pkg::entry_t             ram_wdata;
    snsu_pkg::entry_t             upd_ent;
    logic [snsu_pkg::ENTRY_W-1:0] ram_rdata;
    logic                         upd_go;

    // Statistics table.
    snsu_ram #(
        .WIDTH (snsu_pkg::ENTRY_W),
        .DEPTH (snsu_pkg::NODES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (req.data.node[snsu_pkg::ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // Shared divider for the three means.
    snsu_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .sts   (div_sts),
        .num   (prod_reg),
        .den   (den_reg),
        .quo   (quo)
    );

    assign upd_go = !rsp_valid_reg || rsp.ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            snsu_pkg::ST_CLEAR:
                if (clr_cnt_reg == snsu_pkg::ADDR_W'(snsu_pkg::NODES - 1))
                    state_next = snsu_pkg::ST_IDLE;
            snsu_pkg::ST_IDLE:
                if (req.valid)
                    state_next = snsu_pkg::ST_LOOK;
            snsu_pkg::ST_LOOK:
                state_next = snsu_pkg::ST_PREP;
            snsu_pkg::ST_PREP:
                state_next = need_div ? snsu_pkg::ST_MUL : snsu_pkg::ST_UPD;
            snsu_pkg::ST_MUL:
                state_next = snsu_pkg::ST_DGO;
            snsu_pkg::ST_DGO:
                state_next = snsu_pkg::ST_DWAIT;
            snsu_pkg::ST_DWAIT:
                if (div_sts.done)
                    state_next = snsu_pkg::ST_UPD;
            snsu_pkg::ST_UPD:
                if (upd_go)
                    state_next = snsu_pkg::ST_IDLE;
            default:
                state_next = snsu_pkg::ST_IDLE;
        endcase
    end

    // State machine outputs.
    always_comb
    begin
        req.ready     = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = req_reg.node[snsu_pkg::ADDR_W-1:0];
        ram_wdata     = upd_ent;
        div_ctl.start = 1'b0;
        unique case (state_reg)
            snsu_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            snsu_pkg::ST_IDLE:
                req.ready = 1'b1;
            snsu_pkg::ST_DGO:
                div_ctl.start = 1'b1;
            snsu_pkg::ST_UPD:
                ram_we = upd_go;
            default:
            begin
            end
        endcase
    end

    // Operand preparation: differences to the means and the divisor.
    always_comb
    begin
        logic signed [snsu_pkg::DIFF_W-1:0] v_wl;
        logic signed [snsu_pkg::DIFF_W-1:0] v_d;
        logic signed [snsu_pkg::DIFF_W-1:0] v_m;
        logic [snsu_pkg::DEN_W-1:0]         n_x;
        logic [snsu_pkg::DEN_W-1:0]         mv_x;
        v_wl = snsu_pkg::DIFF_W'(req_reg.value_wl);
        v_d  = snsu_pkg::DIFF_W'(req_reg.value_d);
        v_m  = snsu_pkg::DIFF_W'(req_reg.value_m);
        n_x  = {1'b0, ent_reg.visits};
        mv_x = snsu_pkg::DEN_W'(req_reg.multivisit);
        diff_next[snsu_pkg::LANE_WL] = v_wl - snsu_pkg::DIFF_W'(ent_reg.wl);
        diff_next[snsu_pkg::LANE_D]  = v_d - snsu_pkg::DIFF_W'(ent_reg.d);
        diff_next[snsu_pkg::LANE_M]  = v_m - snsu_pkg::DIFF_W'(ent_reg.m);
        den_next = n_x + mv_x;
        need_div = 1'b0;
        case (req_reg.operation)
            snsu_pkg::OP_FINAL:
                need_div = (den_next != '0);
            snsu_pkg::OP_ADJUST:
            begin
                diff_next[snsu_pkg::LANE_WL] = v_wl;
                diff_next[snsu_pkg::LANE_D]  = v_d;
                diff_next[snsu_pkg::LANE_M]  = v_m;
                den_next = n_x;
                need_div = (n_x != '0);
            end
            snsu_pkg::OP_REVERT:
            begin
                den_next = n_x - mv_x;
                need_div = (n_x > mv_x);
            end
            default:
            begin
            end
        endcase
    end

    // Row update and result from the read row and the quotients.
    always_comb
    begin
        logic [snsu_pkg::DEN_W-1:0]            n_x;
        logic [snsu_pkg::DEN_W-1:0]            mv_x;
        logic [snsu_pkg::DEN_W-1:0]            den_f;
        logic [snsu_pkg::PEND_W:0]             mv_p;
        logic [snsu_pkg::PEND_W:0]             p_x;
        logic signed [snsu_pkg::SUM_W-1:0]     q [snsu_pkg::LANES];
        logic signed [snsu_pkg::SUM_W-1:0]     mean_x [snsu_pkg::LANES];
        logic                                  acc;
        logic [1:0]                            flt;
        n_x   = {1'b0, ent_reg.visits};
        mv_x  = snsu_pkg::DEN_W'(req_reg.multivisit);
        den_f = n_x + mv_x;
        mv_p  = (snsu_pkg::PEND_W + 1)'(req_reg.multivisit);
        p_x   = {1'b0, ent_reg.pending};
        mean_x[snsu_pkg::LANE_WL] = snsu_pkg::SUM_W'(ent_reg.wl);
        mean_x[snsu_pkg::LANE_D]  = snsu_pkg::SUM_W'(ent_reg.d);
        mean_x[snsu_pkg::LANE_M]  = snsu_pkg::SUM_W'(ent_reg.m);
        for (int l = 0; l < snsu_pkg::LANES; l++)
        begin
            q[l] = neg_reg[l] ? -snsu_pkg::SUM_W'({1'b0, quo[l]})
                              :  snsu_pkg::SUM_W'({1'b0, quo[l]});
        end
        upd_ent = ent_reg;
        acc     = 1'b1;
        flt     = snsu_pkg::FAULT_NONE;
        case (req_reg.operation)
            snsu_pkg::OP_START:
                if (ent_reg.visits == '0 && ent_reg.pending != '0)
                    acc = 1'b0;
                else if (&ent_reg.pending)
                    flt = snsu_pkg::FAULT_RANGE;
                else
                    upd_ent.pending = ent_reg.pending + snsu_pkg::PEND_W'(1);
            snsu_pkg::OP_CANCEL:
                if (mv_p > p_x)
                begin
                    upd_ent.pending = '0;
                    flt = snsu_pkg::FAULT_RANGE;
                end
                else
                    upd_ent.pending = snsu_pkg::PEND_W'(p_x - mv_p);
            snsu_pkg::OP_FINAL:
            begin
                if (den_f == '0)
                    flt = snsu_pkg::FAULT_DIV0;
                else
                begin
                    upd_ent.wl = snsu_pkg::sat_wl(mean_x[snsu_pkg::LANE_WL] + q[snsu_pkg::LANE_WL]);
                    upd_ent.d  = snsu_pkg::sat_wl(mean_x[snsu_pkg::LANE_D] + q[snsu_pkg::LANE_D]);
                    upd_ent.m  = snsu_pkg::sat_m(mean_x[snsu_pkg::LANE_M] + q[snsu_pkg::LANE_M]);
                end
                if (den_f[snsu_pkg::DEN_W-1])
                begin
                    upd_ent.visits = '1;
                    if (flt == snsu_pkg::FAULT_NONE)
                        flt = snsu_pkg::FAULT_RANGE;
                end
                else
                    upd_ent.visits = den_f[snsu_pkg::VIS_W-1:0];
                if (mv_p > p_x)
                begin
                    upd_ent.pending = '0;
                    if (flt == snsu_pkg::FAULT_NONE)
                        flt = snsu_pkg::FAULT_RANGE;
                end
                else
                    upd_ent.pending = snsu_pkg::PEND_W'(p_x - mv_p);
            end
            snsu_pkg::OP_ADJUST:
                if (ent_reg.visits == '0)
                    flt = snsu_pkg::FAULT_DIV0;
                else
                begin
                    upd_ent.wl = snsu_pkg::sat_wl(mean_x[snsu_pkg::LANE_WL] + q[snsu_pkg::LANE_WL]);
                    upd_ent.d  = snsu_pkg::sat_wl(mean_x[snsu_pkg::LANE_D] + q[snsu_pkg::LANE_D]);
                    upd_ent.m  = snsu_pkg::sat_m(mean_x[snsu_pkg::LANE_M] + q[snsu_pkg::LANE_M]);
                end
            snsu_pkg::OP_REVERT:
                if (n_x <= mv_x)
                begin
                    if (n_x < mv_x)
                        flt = snsu_pkg::FAULT_RANGE;
                    upd_ent.wl     = '0;
                    upd_ent.d      = snsu_pkg::Q_ONE;
                    upd_ent.m      = '0;
                    upd_ent.visits = '0;
                end
                else
                begin
                    upd_ent.wl = snsu_pkg::sat_wl(mean_x[snsu_pkg::LANE_WL] - q[snsu_pkg::LANE_WL]);
                    upd_ent.d  = snsu_pkg::sat_wl(mean_x[snsu_pkg::LANE_D] - q[snsu_pkg::LANE_D]);
                    upd_ent.m  = snsu_pkg::sat_m(mean_x[snsu_pkg::LANE_M] - q[snsu_pkg::LANE_M]);
                    upd_ent.visits = snsu_pkg::VIS_W'(n_x - mv_x);
                end
            snsu_pkg::OP_MAKE:
            begin
                upd_ent.kind = req_reg.terminal_kind;
                upd_ent.m    = req_reg.value_m;
                case (req_reg.game_result)
                    snsu_pkg::RES_DRAW:
                    begin
                        upd_ent.wl = '0;
                        upd_ent.d  = snsu_pkg::Q_ONE;
                    end
                    snsu_pkg::RES_WHITE:
                    begin
                        upd_ent.wl = snsu_pkg::Q_ONE;
                        upd_ent.d  = '0;
                    end
                    snsu_pkg::RES_BLACK:
                    begin
                        upd_ent.wl = snsu_pkg::Q_NEG_ONE;
                        upd_ent.d  = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
        rsp_next.accepted = acc;
        rsp_next.fault    = flt;
        rsp_next.mean_wl  = upd_ent.wl;
        rsp_next.mean_d   = upd_ent.d;
        rsp_next.mean_m   = upd_ent.m;
        rsp_next.visits   = upd_ent.visits;
        rsp_next.pending  = upd_ent.pending;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= snsu_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == snsu_pkg::ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + snsu_pkg::ADDR_W'(1);
            if (state_reg == snsu_pkg::ST_UPD && upd_go)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
            req_reg <= req.data;
        if (state_reg == snsu_pkg::ST_LOOK)
            ent_reg <= snsu_pkg::entry_t'(ram_rdata);
        if (state_reg == snsu_pkg::ST_PREP)
        begin
            for (int l = 0; l < snsu_pkg::LANES; l++)
                diff_reg[l] <= diff_next[l];
            den_reg <= den_next;
        end
        if (state_reg == snsu_pkg::ST_MUL)
        begin
            for (int l = 0; l < snsu_pkg::LANES; l++)
            begin
                logic [snsu_pkg::DIFF_W-1:0] mag;
                mag = diff_reg[l][snsu_pkg::DIFF_W-1] ? snsu_pkg::DIFF_W'(-diff_reg[l])
                                                      : snsu_pkg::DIFF_W'(diff_reg[l]);
                prod_reg[l] <= mag[snsu_pkg::MAG_W-1:0] * req_reg.multivisit;
                neg_reg[l]  <= diff_reg[l][snsu_pkg::DIFF_W-1];
            end
        end
        if (state_reg == snsu_pkg::ST_UPD && upd_go)
            rsp_reg <= rsp_next;
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

    // A new result appears only when a row is written back.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == snsu_pkg::ST_UPD && ram_we))
        else $error("result raised without a row write-back");

    // The divider is started only when idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_ctl.start |-> !div_sts.busy)
        else $error("divider started while busy");

    // The divider finishes only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.done |-> state_reg == snsu_pkg::ST_DWAIT)
        else $error("divider finished outside the wait state");

    // No request is taken during the clearing pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == snsu_pkg::ST_CLEAR |-> !req.ready && !rsp_valid_reg)
        else $error("activity during clearing pass");

endmodule

// ===== tb/sv/tb_search_node_statistics_update.sv =====
// Testbench for the search node statistics update block.
// Depends on snsu_pkg, snsu_if and the block's top level; keeps its own node table.
`timescale 1ns / 1ps

import snsu_pkg::*;

// Predicts each row read-back and compares it with what the block returns.
class node_stats_scoreboard;
    logic signed [63:0] wl_tab [NODES];
    logic signed [63:0] d_tab [NODES];
    logic signed [63:0] m_tab [NODES];
    longint             vis_tab [NODES];
    longint             pend_tab [NODES];
    logic [1:0]         kind_tab [NODES];
    rsp_t               expected_rows [$];
    int                 errors;

    function new();
        for (int i = 0; i < NODES; i++)
        begin
            wl_tab[i] = 0;
            d_tab[i] = 0;
            m_tab[i] = 0;
            vis_tab[i] = 0;
            pend_tab[i] = 0;
            kind_tab[i] = 0;
        end
        errors = 0;
    endfunction

    // Saturate to a signed field of the given width.
    function automatic longint sat(longint v, int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    // Applies one accepted transaction to the table and queues the row it yields.
    function void note_request(req_t r);
        int     idx;
        longint mv, n, p, nn, vwl, vd, vm;
        logic   granted;
        logic [1:0] flt;
        rsp_t   row;
        idx = int'(r.node) % NODES;
        mv = longint'(r.multivisit);
        vwl = longint'(r.value_wl);
        vd = longint'(r.value_d);
        vm = longint'(r.value_m);
        n = vis_tab[idx];
        p = pend_tab[idx];
        granted = 1'b1;
        flt = FAULT_NONE;
        case (r.operation)
            OP_START:
            begin
                if (n == 0 && p > 0)
                    granted = 1'b0;
                else if (p >= 65535)
                    flt = FAULT_RANGE;
                else
                    pend_tab[idx] = p + 1;
            end
            OP_CANCEL:
            begin
                if (mv > p)
                begin
                    flt = FAULT_RANGE;
                    pend_tab[idx] = 0;
                end
                else
                    pend_tab[idx] = p - mv;
            end
            OP_FINAL:
            begin
                nn = n + mv;
                if (nn == 0)
                    flt = FAULT_DIV0;
                else
                begin
                    wl_tab[idx] = sat(wl_tab[idx] + mv * (vwl - wl_tab[idx]) / nn, 16);
                    d_tab[idx] = sat(d_tab[idx] + mv * (vd - d_tab[idx]) / nn, 16);
                    m_tab[idx] = sat(m_tab[idx] + mv * (vm - m_tab[idx]) / nn, 24);
                end
                if (nn > 64'hFFFF_FFFF)
                begin
                    nn = 64'hFFFF_FFFF;
                    if (flt == FAULT_NONE)
                        flt = FAULT_RANGE;
                end
                vis_tab[idx] = nn;
                if (mv > p)
                begin
                    pend_tab[idx] = 0;
                    if (flt == FAULT_NONE)
                        flt = FAULT_RANGE;
                end
                else
                    pend_tab[idx] = p - mv;
            end
            OP_ADJUST:
            begin
                if (n == 0)
                    flt = FAULT_DIV0;
                else
                begin
                    wl_tab[idx] = sat(wl_tab[idx] + mv * vwl / n, 16);
                    d_tab[idx] = sat(d_tab[idx] + mv * vd / n, 16);
                    m_tab[idx] = sat(m_tab[idx] + mv * vm / n, 24);
                end
            end
            OP_REVERT:
            begin
                nn = n - mv;
                if (nn <= 0)
                begin
                    if (nn < 0)
                        flt = FAULT_RANGE;
                    wl_tab[idx] = 0;
                    d_tab[idx] = longint'(Q_ONE);
                    m_tab[idx] = 0;
                    vis_tab[idx] = 0;
                end
                else
                begin
                    wl_tab[idx] = sat(wl_tab[idx] - mv * (vwl - wl_tab[idx]) / nn, 16);
                    d_tab[idx] = sat(d_tab[idx] - mv * (vd - d_tab[idx]) / nn, 16);
                    m_tab[idx] = sat(m_tab[idx] - mv * (vm - m_tab[idx]) / nn, 24);
                    vis_tab[idx] = nn;
                end
            end
            OP_MAKE:
            begin
                kind_tab[idx] = r.terminal_kind;
                m_tab[idx] = vm;
                if (r.game_result == RES_DRAW)
                begin
                    wl_tab[idx] = 0;
                    d_tab[idx] = longint'(Q_ONE);
                end
                else if (r.game_result == RES_WHITE)
                begin
                    wl_tab[idx] = longint'(Q_ONE);
                    d_tab[idx] = 0;
                end
                else if (r.game_result == RES_BLACK)
                begin
                    wl_tab[idx] = longint'(Q_NEG_ONE);
                    d_tab[idx] = 0;
                end
            end
            default:
            begin
            end
        endcase
        row.accepted = granted;
        row.fault = flt;
        row.mean_wl = wl_tab[idx][15:0];
        row.mean_d = d_tab[idx][15:0];
        row.mean_m = m_tab[idx][23:0];
        row.visits = vis_tab[idx][31:0];
        row.pending = pend_tab[idx][15:0];
        expected_rows = {expected_rows, row};
    endfunction

    // Compares a returned row with the oldest prediction.
    function void check_row(rsp_t got);
        rsp_t want;
        if (expected_rows.size() == 0)
        begin
            $error("unexpected row returned: %p", got);
            errors++;
            return;
        end
        want = expected_rows.pop_front();
        if (got.accepted !== want.accepted)
        begin
            $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
            errors++;
        end
        if (got.fault !== want.fault)
        begin
            $error("fault: expected %0d, got %0d", want.fault, got.fault);
            errors++;
        end
        if (got.mean_wl !== want.mean_wl)
        begin
            $error("mean_wl: expected %0d, got %0d", want.mean_wl, got.mean_wl);
            errors++;
        end
        if (got.mean_d !== want.mean_d)
        begin
            $error("mean_d: expected %0d, got %0d", want.mean_d, got.mean_d);
            errors++;
        end
        if (got.mean_m !== want.mean_m)
        begin
            $error("mean_m: expected %0d, got %0d", want.mean_m, got.mean_m);
            errors++;
        end
        if (got.visits !== want.visits)
        begin
            $error("visits: expected %0d, got %0d", want.visits, got.visits);
            errors++;
        end
        if (got.pending !== want.pending)
        begin
            $error("pending: expected %0d, got %0d", want.pending, got.pending);
            errors++;
        end
    endfunction
endclass

module tb_search_node_statistics_update;

    logic clk;
    logic rst_n;
    logic stim_done;
    logic hold_rsp;

    snsu_req_if req_ch ();
    snsu_rsp_if rsp_ch ();

    node_stats_scoreboard board;

    search_node_statistics_update dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // Free-running clock, 12 ns period.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Nodes used by the random part; a small pool so that rows build up history.
    function automatic logic [NODE_W-1:0] pick_node();
        if ($urandom_range(0, 9) == 0)
            return NODE_W'($urandom);
        return NODE_W'($urandom_range(0, 15));
    endfunction

    // Builds a random request, mostly well-formed start/finalize traffic.
    function automatic req_t random_request();
        req_t r;
        int   sel;
        r = req_t'($bits(req_t)'({$urandom, $urandom, $urandom}));
        r.node = pick_node();
        sel = $urandom_range(0, 99);
        if (sel < 30)
            r.operation = OP_START;
        else if (sel < 55)
            r.operation = OP_FINAL;
        else if (sel < 62)
            r.operation = OP_CANCEL;
        else if (sel < 72)
            r.operation = OP_ADJUST;
        else if (sel < 80)
            r.operation = OP_REVERT;
        else if (sel < 88)
            r.operation = OP_MAKE;
        else
            r.operation = 3'($urandom_range(6, 7));
        if ($urandom_range(0, 3) != 0)
            r.multivisit = MV_W'($urandom_range(1, 4));
        if ($urandom_range(0, 2) != 0)
        begin
            r.value_wl = WL_W'($signed($urandom_range(0, 32768)) - 16384);
            r.value_d = WL_W'($urandom_range(0, 16384));
        end
        return r;
    endfunction

    // Offers one transaction, after a random gap if gaps is set, and waits for its acceptance.
    task automatic send_request(req_t r, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= r;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        board.note_request(r);
    endtask

    function automatic req_t make_req(logic [2:0] op, int node, int wl, int d, int m,
                                      int mv, int res, int kind);
        req_t r;
        r.operation = op;
        r.node = NODE_W'(node);
        r.value_wl = WL_W'(wl);
        r.value_d = WL_W'(d);
        r.value_m = M_W'(m);
        r.multivisit = MV_W'(mv);
        r.game_result = 2'(res);
        r.terminal_kind = 2'(kind);
        return r;
    endfunction

    // Stimulus: directed corner cases first, then random traffic.
    initial
    begin
        board = new();
        stim_done = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Division by zero on an untouched row, then start refused with pending visits.
        send_request(make_req(OP_ADJUST, 3, 100, 100, 100, 1, 0, 0), 1'b0);
        send_request(make_req(OP_FINAL, 3, 0, 0, 0, 0, 0, 0), 1'b0);
        send_request(make_req(OP_START, 3, 0, 0, 0, 1, 0, 0), 1'b0);
        send_request(make_req(OP_START, 3, 0, 0, 0, 1, 0, 0), 1'b0);
        // Finalize at the value extremes, with pending underflow.
        send_request(make_req(OP_FINAL, 3, 32767, -32768, 8388607, 4095, 0, 0), 1'b1);
        send_request(make_req(OP_FINAL, 3, -32768, 32767, -8388608, 1, 0, 0), 1'b1);
        send_request(make_req(OP_START, 3, 0, 0, 0, 1, 0, 0), 1'b1);
        send_request(make_req(OP_CANCEL, 3, 0, 0, 0, 4095, 0, 0), 1'b1);
        send_request(make_req(OP_ADJUST, 3, 32767, -32768, 8388607, 4095, 0, 0), 1'b1);
        send_request(make_req(OP_REVERT, 3, -32768, 32767, -8388608, 1, 0, 0), 1'b1);
        // Revert beyond the visit count resets the row with a range fault.
        send_request(make_req(OP_REVERT, 3, 0, 0, 0, 4095, 0, 0), 1'b1);
        send_request(make_req(OP_REVERT, 3, 0, 0, 0, 1, 0, 0), 1'b1);
        // Every game result, including the unused one, and every terminal kind.
        send_request(make_req(OP_MAKE, 1023, 0, 0, 8388607, 1, 0, 0), 1'b1);
        send_request(make_req(OP_MAKE, 1023, 0, 0, -8388608, 1, 1, 1), 1'b1);
        send_request(make_req(OP_MAKE, 1023, 0, 0, 256, 1, 2, 2), 1'b1);
        send_request(make_req(OP_MAKE, 1023, 0, 0, -256, 1, 3, 3), 1'b1);
        send_request(make_req(OP_READ, 1023, 0, 0, 0, 1, 0, 0), 1'b1);
        send_request(make_req(3'd7, 1023, 0, 0, 0, 1, 0, 0), 1'b1);
        send_request(make_req(OP_START, 0, 0, 0, 0, 1, 0, 0), 1'b1);
        send_request(make_req(OP_CANCEL, 0, 0, 0, 0, 1, 0, 0), 1'b1);

        // Random traffic.
        repeat (1300)
            send_request(random_request(), $urandom_range(0, 3) != 0);
        req_ch.valid <= 1'b0;
        stim_done <= 1'b1;
    end

    // Long hold-off of the receiver, so that the block backs up and stalls its input.
    initial
    begin
        hold_rsp = 1'b0;
        @(posedge rst_n);
        repeat (3000) @(posedge clk);
        hold_rsp <= 1'b1;
        repeat (400) @(posedge clk);
        hold_rsp <= 1'b0;
    end

    // Receiver: a random pause before each transaction, and none taken while held off.
    initial
    begin
        int wait_cycles;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            wait_cycles = $urandom_range(0, 15);
            if (wait_cycles > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            while (hold_rsp)
            begin
                rsp_ch.ready <= 1'b0;
                @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
            board.check_row(rsp_ch.data);
        end
    end

    // End of run: drain the expectations, then allow for any stray output.
    initial
    begin
        @(posedge clk);
        wait (stim_done === 1'b1);
        while (board.expected_rows.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (board.errors == 0 && board.expected_rows.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog, well beyond the slowest legal run.
    initial
    begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
